[rtl/core/blh_pkg.sv]
`default_nettype none
package blh_pkg;

	localparam int POS_W   = 24;
	localparam int MAG_W   = 25;
	localparam int SUM_W   = 50;
	localparam int ROOT_W  = 25;
	localparam int RREM_W  = 27;
	localparam int BW_W    = 16;
	localparam int BC_W    = 8;
	localparam int BIN_W   = 24;
	localparam int CNT_W   = 32;
	localparam int STEP_W  = 5;
	localparam logic [STEP_W-1:0] STEP_LAST = 5'd24;
	localparam logic [BIN_W-1:0] BIN_SAT = 24'hFFFFFF;
	localparam logic [CNT_W-1:0] CNT_SAT = 32'hFFFFFFFF;

	localparam logic CMD_ACCUM = 1'b0;
	localparam logic CMD_READ  = 1'b1;

	localparam logic REG_BIN_WIDTH = 1'b0;
	localparam logic REG_BIN_COUNT = 1'b1;

	typedef struct packed {
		logic              command;
		logic [1:0]        molecule_type;
		logic [2:0]        bead_type_a;
		logic [2:0]        bead_type_b;
		logic signed [23:0] pos_a_x;
		logic signed [23:0] pos_a_y;
		logic signed [23:0] pos_a_z;
		logic signed [23:0] pos_b_x;
		logic signed [23:0] pos_b_y;
		logic signed [23:0] pos_b_z;
		logic [6:0]        read_bin;
	} item_t;

	typedef struct packed {
		logic [23:0] bin_index;
		logic        counted;
		logic [31:0] bin_total;
		logic [31:0] pair_total;
	} result_t;

	typedef struct packed {
		logic              done;
		logic [ROOT_W-1:0] quot;
	} dist_res_t;

	typedef enum logic [1:0] {
		DS_IDLE,
		DS_MUL,
		DS_ROOT,
		DS_DIV
	} dist_state_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIST,
		ST_LOOKUP,
		ST_UPDATE
	} core_state_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		sat_inc = (v == CNT_SAT) ? v : v + 1'b1;
	endfunction

endpackage
`default_nettype wire

[rtl/core/bond_length_histogram_core.sv]
// Bond length histogram core.
// Items enter on item when start is high and busy is low. An accumulate
// beat measures the bond length, bins it by bin_width and, when the bin is
// below bin_count and MAX_BINS and the keys are in range, increments the bin
// counter and the pair total, both saturating. A read beat returns one
// counter and the pair total.
// Each item gives one result on result, marked by done for one cycle.
// An accumulate squares the axis differences on a shared multiplier, takes
// a bit-serial square root and a bit-serial divide, then does one memory
// read and one write-back. A read does the memory read only. One item is
// in flight at a time; busy stays high through the write-back, so a new
// item can be accepted in the cycle done is shown.
// The receiver cannot stall; results are never held.
// After reset the block sweeps both counter memories to zero, one entry per
// cycle, over MOLECULE_TYPES*BEAD_TYPES*BEAD_TYPES*MAX_BINS entries (32768 at
// the defaults), with busy high. Configuration writes via cfg_we are taken
// at any time but must only change while no item is in flight.
`default_nettype none
module bond_length_histogram_core
	import blh_pkg::*;
#(
	parameter int MOLECULE_TYPES = 4,
	parameter int BEAD_TYPES     = 8,
	parameter int MAX_BINS       = 128
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	output logic                 busy,
	input  wire item_t           item,
	output logic                 done,
	output result_t              result,
	input  wire logic            cfg_we,
	input  wire logic            cfg_index,
	input  wire logic [BW_W-1:0] cfg_data
);
	localparam int PAIR_SLOTS = MOLECULE_TYPES * BEAD_TYPES * BEAD_TYPES;
	localparam int HIST_DEPTH = PAIR_SLOTS * MAX_BINS;
	localparam int HIST_AW    = HIST_DEPTH > 1 ? $clog2(HIST_DEPTH) : 1;
	localparam int PAIR_AW    = PAIR_SLOTS > 1 ? $clog2(PAIR_SLOTS) : 1;

	core_state_t state_q, state_d;
	logic [HIST_AW-1:0] clr_q;
	logic [BW_W-1:0]    bw_q;
	logic [BC_W-1:0]    bc_q;
	item_t              item_q;
	logic [BIN_W-1:0]   bin_q;
	logic               bin_ok_q;
	result_t            res_q;
	logic               done_q;
	dist_res_t          dres;

	logic [2:0]         lo, hi;
	logic               key_ok;
	logic [31:0]        pair32, slot32;
	logic [HIST_AW-1:0] hist_addr, hist_waddr;
	logic [PAIR_AW-1:0] pair_addr, pair_waddr;
	logic [CNT_W-1:0]   hist_rd, pair_rd, hist_inc, pair_inc, hist_wd, pair_wd;
	logic               hist_we, pair_we, do_count, read_ok;
	logic [BIN_W-1:0]   bin_calc;
	logic               bin_ok_calc;
	result_t            res_d;

	assign lo     = (item_q.bead_type_a < item_q.bead_type_b) ? item_q.bead_type_a
	                                                          : item_q.bead_type_b;
	assign hi     = (item_q.bead_type_a < item_q.bead_type_b) ? item_q.bead_type_b
	                                                          : item_q.bead_type_a;
	assign key_ok = (32'(item_q.molecule_type) < MOLECULE_TYPES) && (32'(hi) < BEAD_TYPES);
	assign pair32 = (32'(item_q.molecule_type) * BEAD_TYPES + 32'(lo)) * BEAD_TYPES + 32'(hi);
	assign slot32 = pair32 * MAX_BINS
	              + ((item_q.command == CMD_READ) ? 32'(item_q.read_bin) : 32'(bin_q));
	assign hist_addr = HIST_AW'(slot32);
	assign pair_addr = PAIR_AW'(pair32);
	assign read_ok   = key_ok && (32'(item_q.read_bin) < MAX_BINS);
	assign do_count  = (item_q.command == CMD_ACCUM) && key_ok && bin_ok_q;

	// Bin from the divider quotient; a zero width never counts.
	always_comb begin
		if (bw_q == '0) begin
			bin_calc    = BIN_SAT;
			bin_ok_calc = 1'b0;
		end else begin
			bin_calc    = (dres.quot > ROOT_W'(BIN_SAT)) ? BIN_SAT : BIN_W'(dres.quot);
			bin_ok_calc = (dres.quot < ROOT_W'(bc_q)) && (32'(dres.quot) < MAX_BINS);
		end
	end

	blh_dist u_dist (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (state_q == ST_IDLE && start && item.command == CMD_ACCUM),
		.item      (item),
		.bin_width (bw_q),
		.res       (dres)
	);

	assign hist_inc = sat_inc(hist_rd);
	assign pair_inc = sat_inc(pair_rd);

	assign hist_we    = (state_q == ST_CLEAR) || (state_q == ST_UPDATE && do_count);
	assign pair_we    = ((state_q == ST_CLEAR) && (32'(clr_q) < PAIR_SLOTS))
	                 || (state_q == ST_UPDATE && do_count);
	assign hist_waddr = (state_q == ST_CLEAR) ? clr_q : hist_addr;
	assign pair_waddr = (state_q == ST_CLEAR) ? PAIR_AW'(clr_q) : pair_addr;
	assign hist_wd    = (state_q == ST_CLEAR) ? '0 : hist_inc;
	assign pair_wd    = (state_q == ST_CLEAR) ? '0 : pair_inc;

	blh_ram #(.WIDTH(CNT_W), .DEPTH(HIST_DEPTH)) u_hist_ram (
		.clk   (clk),
		.we    (hist_we),
		.waddr (hist_waddr),
		.wdata (hist_wd),
		.re    (state_q == ST_LOOKUP),
		.raddr (hist_addr),
		.rdata (hist_rd)
	);

	blh_ram #(.WIDTH(CNT_W), .DEPTH(PAIR_SLOTS)) u_pair_ram (
		.clk   (clk),
		.we    (pair_we),
		.waddr (pair_waddr),
		.wdata (pair_wd),
		.re    (state_q == ST_LOOKUP),
		.raddr (pair_addr),
		.rdata (pair_rd)
	);

	always_comb begin
		res_d = '0;
		if (item_q.command == CMD_READ) begin
			res_d.bin_index  = BIN_W'(item_q.read_bin);
			res_d.bin_total  = read_ok ? hist_rd : '0;
			res_d.pair_total = key_ok ? pair_rd : '0;
		end else begin
			res_d.bin_index  = bin_q;
			res_d.counted    = do_count;
			res_d.bin_total  = do_count ? hist_inc : '0;
			res_d.pair_total = !key_ok ? '0 : (do_count ? pair_inc : pair_rd);
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR:  if (clr_q == HIST_AW'(HIST_DEPTH - 1)) state_d = ST_IDLE;
			ST_IDLE: begin
				if (start) begin
					state_d = (item.command == CMD_READ) ? ST_LOOKUP : ST_DIST;
				end
			end
			ST_DIST:   if (dres.done) state_d = ST_LOOKUP;
			ST_LOOKUP: state_d = ST_UPDATE;
			ST_UPDATE: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			bw_q    <= 16'd256;
			bc_q    <= 8'd128;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == ST_UPDATE);
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					REG_BIN_WIDTH: bw_q <= cfg_data;
					REG_BIN_COUNT: bc_q <= BC_W'(cfg_data);
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			item_q <= item;
		end
		if (state_q == ST_DIST && dres.done) begin
			bin_q    <= bin_calc;
			bin_ok_q <= bin_ok_calc;
		end
		if (state_q == ST_UPDATE) begin
			res_q <= res_d;
		end
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = res_q;

`ifndef SYNTHESIS
	a_done_after_update: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_UPDATE))
		else $error("result beat without a write-back cycle");
	a_write_states: assert property (@(posedge clk) disable iff (!arst_n)
		(hist_we || pair_we) |-> (state_q == ST_CLEAR || state_q == ST_UPDATE))
		else $error("counter memory written outside clear or write-back");
	a_counted_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.counted) |-> (result.bin_total != '0 && result.pair_total != '0))
		else $error("counted beat reports a zero total");
	a_dist_in_state: assert property (@(posedge clk) disable iff (!arst_n)
		dres.done |-> (state_q == ST_DIST))
		else $error("distance unit finished while no accumulate was pending");
`endif
endmodule
`default_nettype wire

[rtl/core/blh_ram.sv]
`default_nettype none
module blh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                      wdata,
	input  wire logic                                  re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

[rtl/core/blh_dist.sv]
`default_nettype none
module blh_dist
	import blh_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire item_t           item,
	input  wire logic [BW_W-1:0] bin_width,
	output dist_res_t            res
);
	dist_state_t state_q, state_d;
	logic [STEP_W-1:0] step_q;
	logic [MAG_W-1:0]  mag_q [3];
	logic [SUM_W-1:0]  prod_q, acc_q, rad_q;
	logic [RREM_W-1:0] rrem_q;
	logic [ROOT_W-1:0] root_q, div_q;
	logic [BW_W-1:0]   drem_q;
	logic              done_q;

	logic [RREM_W+1:0] rrem_next, rtrial;
	logic              rtake;
	logic [ROOT_W-1:0] root_next;
	logic [BW_W:0]     drem_next;
	logic              dtake;
	logic [MAG_W-1:0]  mag_sel;

	function automatic logic [MAG_W-1:0] abs_diff(input logic signed [POS_W-1:0] a,
		input logic signed [POS_W-1:0] b);
		logic signed [MAG_W-1:0] d;
		d = MAG_W'(a) - MAG_W'(b);
		abs_diff = d[MAG_W-1] ? MAG_W'(-d) : MAG_W'(d);
	endfunction

	assign rrem_next = {rrem_q, rad_q[SUM_W-1 -: 2]};
	assign rtrial    = (RREM_W+2)'({root_q, 2'b01});
	assign rtake     = rrem_next >= rtrial;
	assign root_next = {root_q[ROOT_W-2:0], rtake};

	assign drem_next = {drem_q, div_q[ROOT_W-1]};
	assign dtake     = drem_next >= {1'b0, bin_width};

	assign mag_sel = (step_q[1:0] == 2'd3) ? '0 : mag_q[step_q[1:0]];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			DS_IDLE: if (start) state_d = DS_MUL;
			DS_MUL:  if (step_q[1:0] == 2'd3) state_d = DS_ROOT;
			DS_ROOT: if (step_q == STEP_LAST) state_d = DS_DIV;
			DS_DIV:  if (step_q == STEP_LAST) state_d = DS_IDLE;
			default: state_d = DS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DS_IDLE;
			step_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == DS_DIV) && (step_q == STEP_LAST);
			if (state_d != state_q) begin
				step_q <= '0;
			end else begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			DS_IDLE: begin
				mag_q[0] <= abs_diff(item.pos_a_x, item.pos_b_x);
				mag_q[1] <= abs_diff(item.pos_a_y, item.pos_b_y);
				mag_q[2] <= abs_diff(item.pos_a_z, item.pos_b_z);
				prod_q   <= '0;
				acc_q    <= '0;
			end
			DS_MUL: begin
				// Squares come from a register so the add stays off the multiplier path.
				prod_q <= mag_sel * mag_sel;
				acc_q  <= acc_q + prod_q;
				rad_q  <= acc_q + prod_q;
				rrem_q <= '0;
				root_q <= '0;
			end
			DS_ROOT: begin
				rad_q  <= rad_q << 2;
				rrem_q <= rtake ? RREM_W'(rrem_next - rtrial) : RREM_W'(rrem_next);
				root_q <= root_next;
				if (step_q == STEP_LAST) begin
					div_q  <= root_next;
					drem_q <= '0;
				end
			end
			DS_DIV: begin
				drem_q <= dtake ? BW_W'(drem_next - {1'b0, bin_width}) : BW_W'(drem_next);
				div_q  <= {div_q[ROOT_W-2:0], dtake};
			end
			default: ;
		endcase
	end

	assign res.done = done_q;
	assign res.quot = div_q;
endmodule
`default_nettype wire

[tb/sv/bond_length_histogram_core_test.sv]
`default_nettype none
module bond_length_histogram_core_test;
	import blh_pkg::*;

	localparam int MOL_N = 4;
	localparam int BEAD_N = 8;
	localparam int BIN_N = 128;
	localparam int CYCLE_LIMIT = 1500000;
	localparam int SETTLE = 80;
	localparam int ITEM_W = $bits(item_t);

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	item_t item;
	logic done;
	result_t result;
	logic cfg_we;
	logic cfg_index;
	logic [BW_W-1:0] cfg_data;

	bond_length_histogram_core i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Shadow of the block's counters and configuration.
	logic [31:0] bin_counts [MOL_N*BEAD_N*BEAD_N*BIN_N];
	logic [31:0] pair_counts [MOL_N*BEAD_N*BEAD_N];
	logic [15:0] width_q88;
	logic [7:0] active_bins;

	item_t pending_items [$];
	result_t expected_results [$];
	int errors;
	int idle_pct;
	longint cycles;

	function automatic logic [49:0] dist_sq(input item_t it);
		longint dx, dy, dz;
		dx = longint'(it.pos_a_x) - longint'(it.pos_b_x);
		dy = longint'(it.pos_a_y) - longint'(it.pos_b_y);
		dz = longint'(it.pos_a_z) - longint'(it.pos_b_z);
		return 50'(dx * dx + dy * dy + dz * dz);
	endfunction

	function automatic logic [24:0] int_sqrt(input logic [49:0] n);
		logic [49:0] rem;
		logic [49:0] root;
		logic [49:0] bit_v;
		rem = n;
		root = 0;
		bit_v = 50'd1 << 48;
		while (bit_v > rem)
			bit_v >>= 2;
		while (bit_v != 0) begin
			if (rem >= root + bit_v) begin
				rem -= root + bit_v;
				root = (root >> 1) + bit_v;
			end else begin
				root >>= 1;
			end
			bit_v >>= 2;
		end
		return root[24:0];
	endfunction

	function automatic logic [31:0] bump(input logic [31:0] v);
		return (v == 32'hFFFFFFFF) ? v : v + 1;
	endfunction

	function automatic result_t bin_bond(input item_t it);
		result_t r;
		logic [2:0] lo, hi;
		int pair, slot;
		logic [24:0] bond_len;
		logic [24:0] bin;
		r = '0;
		lo = (it.bead_type_a < it.bead_type_b) ? it.bead_type_a : it.bead_type_b;
		hi = (it.bead_type_a < it.bead_type_b) ? it.bead_type_b : it.bead_type_a;
		pair = (int'(it.molecule_type) * BEAD_N + lo) * BEAD_N + hi;
		if (it.command == CMD_READ) begin
			r.bin_index = 24'(it.read_bin);
			r.pair_total = pair_counts[pair];
			r.bin_total = bin_counts[pair * BIN_N + it.read_bin];
		end else begin
			if (width_q88 == 0) begin
				r.bin_index = BIN_SAT;
			end else begin
				bond_len = int_sqrt(dist_sq(it));
				bin = bond_len / width_q88;
				r.bin_index = (bin > 25'(BIN_SAT)) ? BIN_SAT : bin[23:0];
				if (bin < active_bins && bin < BIN_N) begin
					slot = pair * BIN_N + int'(bin);
					bin_counts[slot] = bump(bin_counts[slot]);
					pair_counts[pair] = bump(pair_counts[pair]);
					r.bin_total = bin_counts[slot];
					r.counted = 1'b1;
				end
			end
			r.pair_total = pair_counts[pair];
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		errors++;
	endtask

	function automatic logic signed [23:0] rand_coord();
		case ($urandom_range(3))
			0: return 24'($urandom);
			1: return 24'sd8388607 - 24'($urandom_range(3));
			default: return 24'($urandom_range(4000)) - 24'sd2000;
		endcase
	endfunction

	function automatic item_t rand_item();
		item_t it;
		logic signed [23:0] base;
		it = item_t'(ITEM_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom}));
		it.command = ($urandom_range(3) == 0) ? CMD_READ : CMD_ACCUM;
		if ($urandom_range(9) != 0) begin
			// Mostly short bonds so that bins land in range.
			base = rand_coord();
			it.pos_a_x = base;
			it.pos_b_x = base + 24'($urandom_range(1200)) - 24'sd600;
			it.pos_a_y = rand_coord();
			it.pos_b_y = it.pos_a_y + 24'($urandom_range(1200)) - 24'sd600;
			it.pos_a_z = rand_coord();
			it.pos_b_z = it.pos_a_z + 24'($urandom_range(1200)) - 24'sd600;
		end
		return it;
	endfunction

	// Driver.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			item <= '0;
		end else if (!start || !busy) begin
			if (start)
				expected_results.push_back(bin_bond(item));
			if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
				start <= 1'b1;
				item <= pending_items.pop_front();
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor.
	always @(posedge clk) begin
		result_t want;
		cycles++;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected beat", 1, 0);
			end else begin
				want = expected_results.pop_front();
				if (result.bin_index != want.bin_index)
					report_mismatch("bin_index", result.bin_index, want.bin_index);
				if (result.counted != want.counted)
					report_mismatch("counted", result.counted, want.counted);
				if (result.bin_total != want.bin_total)
					report_mismatch("bin_total", result.bin_total, want.bin_total);
				if (result.pair_total != want.pair_total)
					report_mismatch("pair_total", result.pair_total, want.pair_total);
			end
		end
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	task automatic drain();
		while (pending_items.size() > 0 || start || expected_results.size() > 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_BIN_WIDTH)
			width_q88 = val;
		else
			active_bins = val[7:0];
	endtask

	task automatic add_random(input int n);
		for (int k = 0; k < n; k++)
			pending_items.push_back(rand_item());
	endtask

	initial begin
		item_t it;
		errors = 0;
		cycles = 0;
		idle_pct = 38;
		cfg_we = 1'b0;
		cfg_index = REG_BIN_WIDTH;
		cfg_data = '0;
		width_q88 = 16'd256;
		active_bins = 8'd128;
		foreach (bin_counts[k])
			bin_counts[k] = '0;
		foreach (pair_counts[k])
			pair_counts[k] = '0;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: zero length, extremes, swapped bead order, reads.
		it = '0;
		pending_items.push_back(it);
		it.bead_type_a = 3'd7;
		it.bead_type_b = 3'd2;
		it.molecule_type = 2'd3;
		it.pos_b_x = 24'sd300;
		pending_items.push_back(it);
		it.bead_type_a = 3'd2;
		it.bead_type_b = 3'd7;
		pending_items.push_back(it);
		it.pos_a_x = 24'sh7FFFFF;
		it.pos_a_y = 24'sh7FFFFF;
		it.pos_a_z = 24'sh7FFFFF;
		it.pos_b_x = 24'sh800000;
		it.pos_b_y = 24'sh800000;
		it.pos_b_z = 24'sh800000;
		pending_items.push_back(it);
		it.command = CMD_READ;
		it.read_bin = 7'd1;
		pending_items.push_back(it);
		it.read_bin = 7'd127;
		pending_items.push_back(it);
		it.read_bin = 7'd0;
		it.bead_type_a = 3'd0;
		it.bead_type_b = 3'd0;
		it.molecule_type = 2'd0;
		pending_items.push_back(it);
		add_random(12);
		drain();

		// Smallest width: nearly every bond is out of range; large bins saturate.
		write_reg(REG_BIN_WIDTH, 16'd1);
		write_reg(REG_BIN_COUNT, 16'd1);
		add_random(150);
		drain();
		write_reg(REG_BIN_WIDTH, 16'd0);
		add_random(30);
		drain();
		write_reg(REG_BIN_WIDTH, 16'hFFFF);
		write_reg(REG_BIN_COUNT, 16'd128);
		add_random(150);
		drain();

		idle_pct = 79;
		write_reg(REG_BIN_WIDTH, 16'd8);
		write_reg(REG_BIN_COUNT, 16'd64);
		add_random(450);
		drain();

		idle_pct = 0;
		write_reg(REG_BIN_WIDTH, 16'd20);
		write_reg(REG_BIN_COUNT, 16'd100);
		add_random(650);
		drain();

		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
`default_nettype wire

[files.f]
rtl/core/blh_pkg.sv
rtl/core/blh_ram.sv
rtl/core/blh_dist.sv
rtl/core/bond_length_histogram_core.sv
tb/sv/bond_length_histogram_core_test.sv
